// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands for the frame allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hw/rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Frame allocator package
// Types, widths and helper functions shared by the frame allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int FRAME_W    = 12;
   localparam int WIDX_W     = 7;
   localparam int CNT_W      = 8;
   localparam int FC_W       = 13;
   localparam int ADDR_WORDS = 128;

   localparam logic [FC_W-1:0]   FC_RESET  = 13'd4096;
   localparam logic [WORD_W-1:0] FULL_WORD = 32'hFFFF_FFFF;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic              wen;
      logic [WIDX_W-1:0] waddr;
      logic [WORD_W-1:0] wdata;
   } map_wr_type;

   // Position of the lowest clear bit of a word; only meaningful when one exists.
   function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_W-1:0] word);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit physical frame allocator over a used-frame bitmap, scanning one
// bitmap word per cycle through a single read port.
// ----------------------------------------------------------------------------
//   Channel   Ports                     Handshake
//   request   start, busy, req_*        taken when start and not busy
//   result    rsp_valid, rsp_*          one-cycle strobe, cannot be stalled
//   config    csr_valid, csr_ready      written when valid and ready
//
// An allocation scans at most 128 words, up to the frame count, between
// acceptance and the result strobe; the single bitmap read port, one word per
// cycle, sets its pace. A free does the read-modify-write of its word.
// Requests that change nothing answer in the cycle after acceptance. Reset
// marks every frame free at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_frame_allocator #(
   parameter int unsigned MAP_WORDS = 128
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire                              req_cmd,
   input  wire  [bfa_pkg::FRAME_W-1:0]      req_page_frame,
   input  wire                              req_kernel_mode,
   input  wire                              req_writable,
   output logic                             rsp_valid,
   output logic                             rsp_status,
   output logic                             rsp_updated,
   output logic [bfa_pkg::FRAME_W-1:0]      rsp_new_frame,
   output logic                             rsp_present,
   output logic                             rsp_read_write,
   output logic                             rsp_user_access,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [bfa_pkg::FC_W-1:0]         csr_frame_count
);

   localparam int unsigned DEPTH =
      (MAP_WORDS < bfa_pkg::ADDR_WORDS) ? MAP_WORDS : bfa_pkg::ADDR_WORDS;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FREE = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [PW-1:0]                 ptr_ff, ptr_in;
   logic [bfa_pkg::FC_W-1:0]      frame_count_ff;
   logic                          kernel_ff, kernel_in;
   logic                          writable_ff, writable_in;
   logic [bfa_pkg::BIT_W-1:0]     free_pos_ff, free_pos_in;
   logic [bfa_pkg::WIDX_W-1:0]    free_idx_ff, free_idx_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_status_ff, rsp_status_in;
   logic                          rsp_updated_ff, rsp_updated_in;
   logic [bfa_pkg::FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   logic                          rsp_present_ff, rsp_present_in;
   logic                          rsp_rw_ff, rsp_rw_in;
   logic                          rsp_user_ff, rsp_user_in;

   logic [bfa_pkg::CNT_W-1:0]     fc_words;
   logic [bfa_pkg::CNT_W-1:0]     scan_words;
   logic                          accept;
   bfa_pkg::map_wr_type           map_wr;
   logic [bfa_pkg::WIDX_W-1:0]    rd_addr;
   logic [bfa_pkg::WORD_W-1:0]    rd_data;
   logic [bfa_pkg::BIT_W-1:0]     hit_pos;

   bfa_map #(
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .wr      (map_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   assign fc_words   = frame_count_ff[bfa_pkg::FC_W-1:bfa_pkg::BIT_W];
   assign scan_words = (fc_words > bfa_pkg::CNT_W'(DEPTH)) ?
                       bfa_pkg::CNT_W'(DEPTH) : fc_words;
   assign hit_pos    = bfa_pkg::lowest_clear(rd_data);

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      kernel_in      = kernel_ff;
      writable_in    = writable_ff;
      free_pos_in    = free_pos_ff;
      free_idx_in    = free_idx_ff;
      rd_addr        = bfa_pkg::WIDX_W'(ptr_ff) + bfa_pkg::WIDX_W'(1);
      map_wr         = '0;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = 1'b0;
      rsp_updated_in = 1'b0;
      rsp_frame_in   = '0;
      rsp_present_in = 1'b0;
      rsp_rw_in      = 1'b0;
      rsp_user_in    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kernel_in   = req_kernel_mode;
               writable_in = req_writable;
               free_pos_in = req_page_frame[bfa_pkg::BIT_W-1:0];
               free_idx_in = req_page_frame[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
               if (req_cmd == bfa_pkg::CMD_ALLOC) begin
                  if (req_page_frame != '0) begin
                     rsp_valid_in = 1'b1;
                  end else if (scan_words == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b1;
                  end else begin
                     rd_addr  = '0;
                     ptr_in   = '0;
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (req_page_frame == '0) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     rd_addr  = req_page_frame[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
                     state_in = ST_FREE;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rd_data != bfa_pkg::FULL_WORD) begin
               map_wr.wen     = 1'b1;
               map_wr.waddr   = bfa_pkg::WIDX_W'(ptr_ff);
               map_wr.wdata   = rd_data | (bfa_pkg::WORD_W'(1) << hit_pos);
               rsp_valid_in   = 1'b1;
               rsp_updated_in = 1'b1;
               rsp_frame_in   = {bfa_pkg::WIDX_W'(ptr_ff), hit_pos};
               rsp_present_in = 1'b1;
               rsp_rw_in      = writable_ff;
               rsp_user_in    = !kernel_ff;
               state_in       = ST_IDLE;
            end else if (bfa_pkg::CNT_W'(ptr_ff) + bfa_pkg::CNT_W'(1) == scan_words) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + PW'(1);
            end
         end
         ST_FREE: begin
            if (bfa_pkg::CNT_W'(free_idx_ff) < bfa_pkg::CNT_W'(DEPTH)) begin
               map_wr.wen   = 1'b1;
               map_wr.waddr = free_idx_ff;
               map_wr.wdata = rd_data & ~(bfa_pkg::WORD_W'(1) << free_pos_ff);
            end
            rsp_valid_in   = 1'b1;
            rsp_updated_in = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_count_ff <= bfa_pkg::FC_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            frame_count_ff <= csr_frame_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      kernel_ff      <= kernel_in;
      writable_ff    <= writable_in;
      free_pos_ff    <= free_pos_in;
      free_idx_ff    <= free_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_updated_ff <= rsp_updated_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_present_ff <= rsp_present_in;
      rsp_rw_ff      <= rsp_rw_in;
      rsp_user_ff    <= rsp_user_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_updated     = rsp_updated_ff;
   assign rsp_new_frame   = rsp_frame_ff;
   assign rsp_present     = rsp_present_ff;
   assign rsp_read_write  = rsp_rw_ff;
   assign rsp_user_access = rsp_user_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bfa_map.sv
// ----------------------------------------------------------------------------
// Frame allocator bitmap
// Used-frame bitmap memory with one write port, one registered read port and
// a valid bit for each word so that words never written read as all free.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_map #(
   parameter int unsigned DEPTH = 128
) (
   input  wire                              clock,
   input  wire                              reset,
   input  bfa_pkg::map_wr_type              wr,
   input  wire  [bfa_pkg::WIDX_W-1:0]       rd_addr,
   output logic [bfa_pkg::WORD_W-1:0]       rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [bfa_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]           vld_ff;
   logic [bfa_pkg::WORD_W-1:0] rd_word_ff;
   logic                       rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.wen) begin
         mem_ff[wr.waddr[AW-1:0]] <= wr.wdata;
      end
      rd_word_ff <= mem_ff[rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.wen) begin
            vld_ff[wr.waddr[AW-1:0]] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

// File: hw/rtl/bfa_checker.sv
// ----------------------------------------------------------------------------
// Frame allocator checker
// Port-level assertions on the frame allocator, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bfa_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          start,
   input wire                          busy,
   input wire                          req_cmd,
   input wire [bfa_pkg::FRAME_W-1:0]   req_page_frame,
   input wire                          rsp_valid,
   input wire                          rsp_status,
   input wire                          rsp_updated,
   input wire [bfa_pkg::FRAME_W-1:0]   rsp_new_frame,
   input wire                          rsp_present
);

   logic acc_noop;
   logic acc_free;

   assign acc_noop = start && !busy && (req_page_frame == '0) && (req_cmd == bfa_pkg::CMD_FREE)
                  || start && !busy && (req_page_frame != '0) && (req_cmd == bfa_pkg::CMD_ALLOC);
   assign acc_free = start && !busy && (req_page_frame != '0) && (req_cmd == bfa_pkg::CMD_FREE);

   // An out-of-memory item carries nothing else.
   `ASSERT_NOW(a_oom_clean, clock, reset, rsp_valid && rsp_status, !rsp_updated && !rsp_present && rsp_new_frame == '0)

   // A present page always needs writing back.
   `ASSERT_NOW(a_present_upd, clock, reset, rsp_valid && rsp_present, rsp_updated && !rsp_status)

   // An item that changes nothing is answered in the next cycle with nothing to write back.
   `ASSERT_NEXT(a_noop_answer, clock, reset, acc_noop, rsp_valid && !rsp_updated && !rsp_status)

   // A free of a real frame leaves the block busy in the next cycle, before it answers.
   `ASSERT_NEXT(a_free_busy, clock, reset, acc_free, busy && !rsp_valid)

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_cmd        (req_cmd),
   .req_page_frame (req_page_frame),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_updated    (rsp_updated),
   .rsp_new_frame  (rsp_new_frame),
   .rsp_present    (rsp_present)
);

`default_nettype wire
